FILE: sv/gmd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gmd_pkg: shared types and constants for the grid distance transform
// Holds the sequencer states, neighbor directions, register indexes and the
// structs that pass between the top level and the search core.
// ============================================================================
package gmd_pkg;

    localparam int DIM_W = 7;
    localparam int DIM_MAX = 127;
    localparam int DIM_RESET = 64;
    localparam int LVL_W = 8;
    localparam int DIST_W = 8;

    localparam logic [LVL_W-1:0] DIST_MAX = 8'd127;
    localparam logic signed [DIST_W-1:0] DIST_UNDEF = -8'sd1;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_LEVEL,
        ST_POP,
        ST_NBR,
        ST_CHECK
    } gmd_state_t;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT
    } gmd_dir_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } gmd_dims_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIST_W-1:0] distance;
        logic                     status;
    } gmd_res_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

FILE: sv/gmd_cell_if.sv
`timescale 1ns / 1ps
// ============================================================================
// gmd_cell_if: grid cell channel
// Carries one grid cell per transfer, land or sea, with valid and ready.
// ============================================================================
interface gmd_cell_if;
    logic valid;
    logic ready;
    logic cell_is_land;

    modport source (output valid, output cell_is_land, input ready);
    modport sink (input valid, input cell_is_land, output ready);
endinterface

FILE: sv/gmd_result_if.sv
`timescale 1ns / 1ps
// ============================================================================
// gmd_result_if: distance result channel
// Carries one result per grid: the largest distance and a status flag.
// ============================================================================
interface gmd_result_if;
    logic                    valid;
    logic                    ready;
    logic signed [7:0]       distance;
    logic                    status;

    modport source (output valid, output distance, output status, input ready);
    modport sink (input valid, input distance, input status, output ready);
endinterface

FILE: sv/grid_max_distance_from_land.sv
`timescale 1ns / 1ps
// ============================================================================
// grid_max_distance_from_land: largest sea-to-land distance on a grid
// Loads a land/sea grid cell by cell and reports the largest Manhattan
// distance from any sea cell to its nearest land, found by a search that
// starts from every land cell at once.
// ============================================================================
// Cells are taken one per cycle in row-major order. After the last cell of a
// mixed grid, the cell channel stalls while the search walks the frontier
// queue: each level opens in ST_LEVEL, each dequeued cell in ST_POP, and
// each neighbor is tested against the grid edge in ST_NBR; one inside it is
// checked in ST_CHECK through the single lookup port of the visited
// map. A grid that is all land or all sea gives its result without a search.
// The result sits in an output register, so loading of the next grid starts
// while it waits; only the last cell of that grid holds until it is taken.
// Every cell is written while it loads, so no clearing pass is needed.
// A write to either size register discards a partly loaded grid.
module grid_max_distance_from_land #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [gmd_pkg::DIM_W-1:0]  cfg_data,
    gmd_cell_if.sink                   cells,
    gmd_result_if.source               results
);

    localparam int DW = gmd_pkg::DIM_W;
    localparam int EFF_ROWS = (MAX_ROWS < gmd_pkg::DIM_MAX) ? MAX_ROWS : gmd_pkg::DIM_MAX;
    localparam int EFF_COLS = (MAX_COLS < gmd_pkg::DIM_MAX) ? MAX_COLS : gmd_pkg::DIM_MAX;
    localparam logic [DW-1:0] ROWS_MAX = DW'(EFF_ROWS);
    localparam logic [DW-1:0] COLS_MAX = DW'(EFF_COLS);
    localparam logic [DW-1:0] ROWS_RST = DW'((gmd_pkg::DIM_RESET < EFF_ROWS) ?
                                             gmd_pkg::DIM_RESET : EFF_ROWS);
    localparam logic [DW-1:0] COLS_RST = DW'((gmd_pkg::DIM_RESET < EFF_COLS) ?
                                             gmd_pkg::DIM_RESET : EFF_COLS);

    gmd_pkg::gmd_dims_t dims_reg;
    gmd_pkg::gmd_res_t  core_res;
    logic               out_valid_reg;
    logic signed [7:0]  dist_reg;
    logic               status_reg;
    logic               out_busy;

    assign out_busy = out_valid_reg && !results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.rows <= ROWS_RST;
            dims_reg.cols <= COLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gmd_pkg::REG_GRID_ROWS:
                begin
                    dims_reg.rows <= gmd_pkg::clamp_dim(cfg_data, ROWS_MAX);
                end
                gmd_pkg::REG_GRID_COLS:
                begin
                    dims_reg.cols <= gmd_pkg::clamp_dim(cfg_data, COLS_MAX);
                end
                default:
                begin
                    dims_reg <= dims_reg;
                end
            endcase
        end
    end

    gmd_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cells    (cells),
        .dims     (dims_reg),
        .clear    (cfg_we),
        .out_busy (out_busy),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res.valid)
        begin
            dist_reg <= core_res.distance;
            status_reg <= core_res.status;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.distance = dist_reg;
    assign results.status = status_reg;

endmodule

FILE: sv/gmd_core.sv
`timescale 1ns / 1ps
// ============================================================================
// gmd_core: grid loader and breadth-first search sequencer
// Writes the visited map and frontier queue while cells arrive, then walks
// the queue level by level, one neighbor lookup at a time.
// ============================================================================
module gmd_core #(
    parameter int MAX_ROWS,
    parameter int MAX_COLS
) (
    input  logic              clk,
    input  logic              rst_n,
    gmd_cell_if.sink          cells,
    input  gmd_pkg::gmd_dims_t dims,
    input  logic              clear,
    input  logic              out_busy,
    output gmd_pkg::gmd_res_t res
);

    localparam int DW = gmd_pkg::DIM_W;
    localparam int LW = gmd_pkg::LVL_W;
    localparam int EFF_ROWS = (MAX_ROWS < gmd_pkg::DIM_MAX) ? MAX_ROWS : gmd_pkg::DIM_MAX;
    localparam int EFF_COLS = (MAX_COLS < gmd_pkg::DIM_MAX) ? MAX_COLS : gmd_pkg::DIM_MAX;
    localparam int CAP = EFF_ROWS * EFF_COLS;
    localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int QW = $clog2(CAP + 1);
    localparam int EW = 2 * DW + AW;
    localparam int XW = AW + DW + 1;

    gmd_pkg::gmd_state_t state_reg, state_next;
    gmd_pkg::gmd_dir_t   dir_reg, dir_next;
    logic [DW-1:0]       row_reg, row_next;
    logic [DW-1:0]       col_reg, col_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [QW-1:0]       head_reg, head_next;
    logic [QW-1:0]       tail_reg, tail_next;
    logic [QW-1:0]       lvl_end_reg, lvl_end_next;
    logic [QW-1:0]       sea_reg, sea_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [EW-1:0]       nbr_reg, nbr_next;

    logic                vis_mem [CAP];
    logic [EW-1:0]       q_mem [CAP];
    logic                vis_rd_reg;
    logic [EW-1:0]       q_rd_reg;

    logic                vis_we, vis_wd, vis_re, q_we, q_re;
    logic [AW-1:0]       vis_wa, vis_ra;
    logic [EW-1:0]       q_wd;

    logic                last_cell, accept;
    logic [DW-1:0]       cur_r, cur_c, nbr_r, nbr_c;
    logic [AW-1:0]       cur_p;
    logic [XW-1:0]       p_x, cols_x, np_x;
    logic                nbr_ok;
    logic [EW-1:0]       nbr_entry;
    logic [LW-1:0]       lvl_m1;

    assign last_cell = (row_reg == dims.rows - DW'(1)) && (col_reg == dims.cols - DW'(1));
    assign cells.ready = (state_reg == gmd_pkg::ST_LOAD) && !clear
                         && !(last_cell && out_busy);
    assign accept = cells.valid && cells.ready;

    assign cur_r = q_rd_reg[EW-1 -: DW];
    assign cur_c = q_rd_reg[EW-DW-1 -: DW];
    assign cur_p = q_rd_reg[AW-1:0];
    assign p_x = XW'(cur_p);
    assign cols_x = XW'(dims.cols);
    assign lvl_m1 = level_reg - LW'(1);

    always_comb
    begin
        nbr_ok = 1'b0;
        nbr_r = cur_r;
        nbr_c = cur_c;
        np_x = p_x;
        unique case (dir_reg)
            gmd_pkg::DIR_UP:
            begin
                nbr_ok = (cur_r != '0);
                nbr_r = cur_r - DW'(1);
                np_x = p_x - cols_x;
            end
            gmd_pkg::DIR_RIGHT:
            begin
                nbr_ok = ((DW+1)'(cur_c) + (DW+1)'(1)) < (DW+1)'(dims.cols);
                nbr_c = cur_c + DW'(1);
                np_x = p_x + XW'(1);
            end
            gmd_pkg::DIR_DOWN:
            begin
                nbr_ok = ((DW+1)'(cur_r) + (DW+1)'(1)) < (DW+1)'(dims.rows);
                nbr_r = cur_r + DW'(1);
                np_x = p_x + cols_x;
            end
            gmd_pkg::DIR_LEFT:
            begin
                nbr_ok = (cur_c != '0);
                nbr_c = cur_c - DW'(1);
                np_x = p_x - XW'(1);
            end
            default:
            begin
                nbr_ok = 1'b0;
            end
        endcase
        nbr_entry = {nbr_r, nbr_c, np_x[AW-1:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        dir_next = dir_reg;
        row_next = row_reg;
        col_next = col_reg;
        idx_next = idx_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        lvl_end_next = lvl_end_reg;
        sea_next = sea_reg;
        level_next = level_reg;
        nbr_next = nbr_reg;
        vis_we = 1'b0;
        vis_wa = idx_reg;
        vis_wd = 1'b0;
        vis_re = 1'b0;
        vis_ra = nbr_entry[AW-1:0];
        q_we = 1'b0;
        q_wd = {row_reg, col_reg, idx_reg};
        q_re = 1'b0;
        res.valid = 1'b0;
        res.distance = gmd_pkg::DIST_UNDEF;
        res.status = 1'b1;

        unique case (state_reg)
            gmd_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    vis_we = 1'b1;
                    vis_wd = cells.cell_is_land;
                    if (cells.cell_is_land)
                    begin
                        q_we = 1'b1;
                        tail_next = tail_reg + QW'(1);
                    end
                    else
                    begin
                        sea_next = sea_reg + QW'(1);
                    end
                    idx_next = idx_reg + AW'(1);
                    if (col_reg == dims.cols - DW'(1))
                    begin
                        col_next = '0;
                        row_next = row_reg + DW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + DW'(1);
                    end
                    if (last_cell)
                    begin
                        row_next = '0;
                        col_next = '0;
                        idx_next = '0;
                        if ((tail_next == '0) || (sea_next == '0))
                        begin
                            res.valid = 1'b1;
                            tail_next = '0;
                            sea_next = '0;
                        end
                        else
                        begin
                            state_next = gmd_pkg::ST_LEVEL;
                        end
                    end
                end
            end
            gmd_pkg::ST_LEVEL:
            begin
                if (head_reg == tail_reg)
                begin
                    res.valid = 1'b1;
                    res.status = 1'b0;
                    res.distance = (lvl_m1 > gmd_pkg::DIST_MAX) ?
                                   $signed(gmd_pkg::DIST_MAX) : $signed(lvl_m1);
                    head_next = '0;
                    tail_next = '0;
                    sea_next = '0;
                    level_next = '0;
                    state_next = gmd_pkg::ST_LOAD;
                end
                else
                begin
                    lvl_end_next = tail_reg;
                    level_next = level_reg + LW'(1);
                    state_next = gmd_pkg::ST_POP;
                end
            end
            gmd_pkg::ST_POP:
            begin
                if (head_reg == lvl_end_reg)
                begin
                    state_next = gmd_pkg::ST_LEVEL;
                end
                else
                begin
                    q_re = 1'b1;
                    head_next = head_reg + QW'(1);
                    dir_next = gmd_pkg::DIR_UP;
                    state_next = gmd_pkg::ST_NBR;
                end
            end
            gmd_pkg::ST_NBR:
            begin
                if (nbr_ok)
                begin
                    vis_re = 1'b1;
                    nbr_next = nbr_entry;
                    state_next = gmd_pkg::ST_CHECK;
                end
                else if (dir_reg == gmd_pkg::DIR_LEFT)
                begin
                    state_next = gmd_pkg::ST_POP;
                end
                else
                begin
                    dir_next = gmd_pkg::gmd_dir_t'(2'(dir_reg + 2'd1));
                end
            end
            gmd_pkg::ST_CHECK:
            begin
                if (!vis_rd_reg)
                begin
                    vis_we = 1'b1;
                    vis_wa = nbr_reg[AW-1:0];
                    vis_wd = 1'b1;
                    q_we = 1'b1;
                    q_wd = nbr_reg;
                    tail_next = tail_reg + QW'(1);
                end
                if (dir_reg == gmd_pkg::DIR_LEFT)
                begin
                    state_next = gmd_pkg::ST_POP;
                end
                else
                begin
                    dir_next = gmd_pkg::gmd_dir_t'(2'(dir_reg + 2'd1));
                    state_next = gmd_pkg::ST_NBR;
                end
            end
            default:
            begin
                state_next = gmd_pkg::ST_LOAD;
            end
        endcase

        if (clear)
        begin
            state_next = gmd_pkg::ST_LOAD;
            row_next = '0;
            col_next = '0;
            idx_next = '0;
            head_next = '0;
            tail_next = '0;
            sea_next = '0;
            level_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmd_pkg::ST_LOAD;
            dir_reg <= gmd_pkg::DIR_UP;
            row_reg <= '0;
            col_reg <= '0;
            idx_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            lvl_end_reg <= '0;
            sea_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg <= dir_next;
            row_reg <= row_next;
            col_reg <= col_next;
            idx_reg <= idx_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            lvl_end_reg <= lvl_end_next;
            sea_reg <= sea_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nbr_reg <= nbr_next;
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_wa] <= vis_wd;
        end
        if (vis_re)
        begin
            vis_rd_reg <= vis_mem[vis_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg[AW-1:0]] <= q_wd;
        end
        if (q_re)
        begin
            q_rd_reg <= q_mem[head_reg[AW-1:0]];
        end
    end

endmodule

FILE: sv/gmd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// gmd_checker: port-level assertions for the grid distance block
// Watches the result channel for a held result and for consistent codes.
// ============================================================================
module gmd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic signed [7:0] res_distance,
    input logic              res_status
);

    // A result that is not taken stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_distance) && $stable(res_status))
        else $error("result payload changed while stalled");

    // A uniform grid always reports the undefined distance.
    a_uniform_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status |-> res_distance == -8'sd1)
        else $error("uniform grid with a defined distance");

    // A result with a clear status flag is never negative.
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_status |-> !res_distance[7])
        else $error("valid result with a negative distance");

endmodule

bind grid_max_distance_from_land gmd_checker u_gmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_distance (results.distance),
    .res_status   (results.status)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for grid_max_distance_from_land
// Loads land/sea grids through the cell channel and compares each reported
// distance and status with a pinned table entry or a search run inside the
// bench. A short directed table comes first, then random grids of many
// sizes and densities under varied idling on both channels, one tall grid
// with a single land cell and a long output stall.
// ============================================================================
module testbench;

    localparam int GRID_MAX = 64;
    localparam int GRID_CELLS = GRID_MAX * GRID_MAX;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_UNIFORM = 1'b1;
    localparam int SETTLE_CYCLES = 20;
    localparam int END_CYCLES = 50;
    localparam int QUIET_LIMIT = 200000;
    localparam int PHASE_CELLS = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int SND_IDLE[4] = '{0, 80, 0, 25};
    localparam int RCV_STALL[4] = '{0, 0, 80, 25};

    typedef struct packed {
        logic signed [gmd_pkg::DIST_W-1:0] distance;
        logic                              status;
    } grid_verdict_t;

    typedef struct packed {
        logic [gmd_pkg::DIM_W-1:0]         rows_val;
        logic [gmd_pkg::DIM_W-1:0]         cols_val;
        logic [4:0]                        ncells;
        logic [15:0]                       cells;
        logic                              pinned;
        logic signed [gmd_pkg::DIST_W-1:0] distance;
        logic                              status;
    } grid_case_t;

    // Cell i of a row is bit i of its pattern; rows that stop short of a full
    // grid are discarded by the size write of the following row.
    localparam grid_case_t DIRECTED[9] = '{
        '{7'd0,   7'd1,  5'd1, 16'h0001, 1'b1, gmd_pkg::DIST_UNDEF, STATUS_UNIFORM},
        '{7'd1,   7'd0,  5'd1, 16'h0000, 1'b1, gmd_pkg::DIST_UNDEF, STATUS_UNIFORM},
        '{7'd1,   7'd2,  5'd2, 16'h0001, 1'b1, 8'sd1,               STATUS_OK},
        '{7'd1,   7'd3,  5'd3, 16'h0004, 1'b1, 8'sd2,               STATUS_OK},
        '{7'd2,   7'd2,  5'd4, 16'h0008, 1'b1, 8'sd2,               STATUS_OK},
        '{7'd3,   7'd3,  5'd4, 16'h0005, 1'b0, 8'sd0,               STATUS_OK},
        '{7'd3,   7'd1,  5'd3, 16'h0002, 1'b0, 8'sd0,               STATUS_OK},
        '{7'd127, 7'd65, 5'd2, 16'h0002, 1'b0, 8'sd0,               STATUS_OK},
        '{7'd2,   7'd3,  5'd6, 16'h0021, 1'b0, 8'sd0,               STATUS_OK}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [gmd_pkg::DIM_W-1:0] cfg_data;

    gmd_cell_if cell_link();
    gmd_result_if result_link();

    grid_max_distance_from_land i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cells(cell_link),
        .results(result_link)
    );

    int unsigned span_rows;
    int unsigned span_cols;
    int unsigned cells_in;
    int unsigned sea_cells;
    bit land_map[GRID_CELLS];
    grid_verdict_t expected_verdicts[$];
    logic pinned_on;
    grid_verdict_t pinned_verdict;

    int snd_idle_pct;
    int rcv_stall_pct;
    bit hold_pending;
    int mismatch_count;
    int quiet_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned fit_dim(input logic [gmd_pkg::DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > GRID_MAX)
        begin
            return GRID_MAX;
        end
        return int'(v);
    endfunction

    function automatic grid_verdict_t predict_grid();
        bit reached[GRID_CELLS];
        int unsigned wave[$];
        int dr[4] = '{-1, 0, 1, 0};
        int dc[4] = '{0, 1, 0, -1};
        int unsigned total;
        int unsigned levels;
        int unsigned n;
        int unsigned p;
        int r;
        int c;
        int nr;
        int nc;
        grid_verdict_t v;
        total = span_rows * span_cols;
        if (sea_cells == 0 || sea_cells == total)
        begin
            v = '{gmd_pkg::DIST_UNDEF, STATUS_UNIFORM};
            return v;
        end
        for (p = 0; p < total; p++)
        begin
            reached[p] = land_map[p];
            if (land_map[p])
            begin
                wave.push_back(p);
            end
        end
        levels = 0;
        while (wave.size() > 0)
        begin
            levels++;
            n = wave.size();
            repeat (n)
            begin
                p = wave.pop_front();
                r = int'(p / span_cols);
                c = int'(p % span_cols);
                for (int k = 0; k < 4; k++)
                begin
                    nr = r + dr[k];
                    nc = c + dc[k];
                    if (nr >= 0 && nr < int'(span_rows) && nc >= 0 && nc < int'(span_cols))
                    begin
                        p = nr * span_cols + nc;
                        if (!reached[p])
                        begin
                            reached[p] = 1'b1;
                            wave.push_back(p);
                        end
                    end
                end
            end
        end
        levels = levels - 1;
        if (levels > int'(gmd_pkg::DIST_MAX))
        begin
            levels = int'(gmd_pkg::DIST_MAX);
        end
        v = '{gmd_pkg::DIST_W'(levels), STATUS_OK};
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_cell(input logic land);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            cell_link.valid <= 1'b0;
            @(posedge clk);
        end
        cell_link.valid <= 1'b1;
        cell_link.cell_is_land <= land;
        do
        begin
            @(posedge clk);
        end
        while (!cell_link.ready);
    endtask

    task automatic send_random_grid(input int unsigned total);
        int unsigned kind;
        int unsigned pct;
        kind = $urandom_range(9);
        case (kind)
            0: pct = 0;
            1: pct = 100;
            default:
            begin
                case (kind % 4)
                    0: pct = 50;
                    1: pct = 15;
                    2: pct = 3;
                    default: pct = 85;
                endcase
            end
        endcase
        for (int unsigned i = 0; i < total; i++)
        begin
            send_cell($urandom_range(99) < pct);
        end
    endtask

    task automatic settle();
        cell_link.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [gmd_pkg::DIM_W-1:0] rows_val,
                            input logic [gmd_pkg::DIM_W-1:0] cols_val);
        cfg_we <= 1'b1;
        cfg_index <= gmd_pkg::REG_GRID_ROWS;
        cfg_data <= rows_val;
        @(posedge clk);
        cfg_index <= gmd_pkg::REG_GRID_COLS;
        cfg_data <= cols_val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The output side stalls at random, and once for a long stretch on request.
    initial
    begin
        result_link.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    result_link.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_link.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : track_grid
        grid_verdict_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == gmd_pkg::REG_GRID_ROWS)
                begin
                    span_rows = fit_dim(cfg_data);
                end
                else
                begin
                    span_cols = fit_dim(cfg_data);
                end
                cells_in = 0;
                sea_cells = 0;
            end
            if (cell_link.valid && cell_link.ready)
            begin
                land_map[cells_in] = cell_link.cell_is_land;
                if (!cell_link.cell_is_land)
                begin
                    sea_cells++;
                end
                cells_in++;
                if (cells_in == span_rows * span_cols)
                begin
                    want = pinned_on ? pinned_verdict : predict_grid();
                    expected_verdicts.push_back(want);
                    cells_in = 0;
                    sea_cells = 0;
                end
            end
            if (result_link.valid && result_link.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch($sformatf("result transfer with no grid pending: %0d/%0b",
                                              result_link.distance, result_link.status));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result_link.distance !== want.distance)
                    begin
                        report_mismatch($sformatf("distance %0d, expected %0d",
                                                  result_link.distance, want.distance));
                    end
                    if (result_link.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  result_link.status, want.status));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cell_link.valid && cell_link.ready) || (result_link.valid && result_link.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned total;
        int unsigned sent;
        int unsigned cut;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gmd_pkg::REG_GRID_ROWS;
        cfg_data = '0;
        cell_link.valid = 1'b0;
        cell_link.cell_is_land = 1'b0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_pending = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        pinned_on = 1'b0;
        pinned_verdict = '0;
        span_rows = fit_dim(gmd_pkg::DIM_W'(gmd_pkg::DIM_RESET));
        span_cols = fit_dim(gmd_pkg::DIM_W'(gmd_pkg::DIM_RESET));
        cells_in = 0;
        sea_cells = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[n])
        begin
            settle();
            pinned_on = DIRECTED[n].pinned;
            pinned_verdict = '{DIRECTED[n].distance, DIRECTED[n].status};
            set_dims(DIRECTED[n].rows_val, DIRECTED[n].cols_val);
            for (int i = 0; i < DIRECTED[n].ncells; i++)
            begin
                send_cell(DIRECTED[n].cells[i]);
            end
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            settle();
            pinned_on = 1'b0;
            snd_idle_pct = SND_IDLE[ph % 4];
            rcv_stall_pct = RCV_STALL[ph % 4];
            case (ph)
                4: set_dims(7'd127, 7'd1);
                7: set_dims(7'd1, 7'd100);
                10: set_dims(7'd64, 7'd4);
                default: set_dims(gmd_pkg::DIM_W'($urandom_range(1, 8)),
                                  gmd_pkg::DIM_W'($urandom_range(1, 8)));
            endcase
            total = fit_dim(cfg_data) * span_rows;
            if (ph == 10)
            begin
                // A single land cell in one corner gives the longest distance.
                for (int unsigned i = 0; i < total; i++)
                begin
                    send_cell(i == 0);
                end
            end
            else
            begin
                sent = 0;
                while (sent < PHASE_CELLS)
                begin
                    send_random_grid(total);
                    sent += total;
                end
                if (total > 1 && $urandom_range(1) == 1)
                begin
                    cut = $urandom_range(1, total - 1);
                    for (int unsigned i = 0; i < cut; i++)
                    begin
                        send_cell(1'($urandom_range(1)));
                    end
                end
            end
        end

        settle();
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        set_dims(7'd2, 7'd2);
        hold_pending = 1'b1;
        for (int g = 0; g < 40; g++)
        begin
            send_random_grid(4);
        end

        cell_link.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_verdicts.size() != 0);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/gmd_pkg.sv
sv/gmd_cell_if.sv
sv/gmd_result_if.sv
sv/gmd_core.sv
sv/grid_max_distance_from_land.sv
sv/gmd_checker.sv
verif/testbench.sv
